### rtl/tpc_pkg.sv
// Shared types, constants and MD5 tables for the tunnel password cipher.
`default_nettype none
package tpc_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Register indexes on the configuration port (address bits 5:3).
	localparam logic [2:0] REG_SECRET0 = 3'd0;
	localparam logic [2:0] REG_SECRET1 = 3'd1;
	localparam logic [2:0] REG_SECRET2 = 3'd2;
	localparam logic [2:0] REG_SECRET3 = 3'd3;
	localparam logic [2:0] REG_SECLEN  = 3'd4;
	localparam logic [2:0] REG_MODE    = 3'd5;

	// Cipher modes.
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ENC   = 2'd1;
	localparam logic [1:0] MODE_DEC   = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CLEN = 2'd1;
	localparam logic [1:0] ST_SALT     = 2'd2;
	localparam logic [1:0] ST_BAD_PLEN = 2'd3;

	// Input command codes.
	localparam logic CMD_START = 1'b0;

	// Secret size limit and salt marker.
	localparam logic [5:0]  MAX_SECRET_BYTES = 6'd32;
	localparam logic [15:0] SALT_MARK        = 16'h8000;

	// MD5 initial chaining values.
	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;

	// Byte vectors, first byte at index 0.
	typedef logic [0:31][7:0] bytes32_t;
	typedef logic [0:17][7:0] tail_t;
	typedef logic [0:15][7:0] block16_t;

	typedef enum logic [3:0] {
		S_IN, S_SEED, S_SALT_HI, S_SALT_LO, S_WAIT,
		S_LOAD, S_EMIT, S_NEXT, S_PASS, S_ERR
	} ctrl_state_t;

	typedef enum logic [2:0] {
		PH_NONE, PH_CLEAR, PH_ENC, PH_DSALT, PH_DFIRST, PH_DREST
	} phase_t;

	typedef enum logic [2:0] {
		SRC_SALT_HI, SRC_SALT_LO, SRC_OBUF, SRC_PASS, SRC_ERR
	} emit_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       ld_auth;
		logic       clr_bpos;
		logic       ld_len_byte;
		logic       ld_salt_enc;
		logic       ld_bl_len;
		logic       dec_bl;
		logic       ld_pass;
		logic       wr_chunk;
		logic       wr_salt;
		logic       md5_seed;
		logic       md5_chain;
		logic       ld_obuf;
		logic       first_chunk;
		logic       enc;
		logic       step;
		logic       cc_dec;
		logic       emit;
		emit_src_t  src;
		logic       last;
		logic [1:0] code;
	} tpc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bpos_zero;
		logic bpos_last;
		logic bl_zero;
		logic bl_one;
		logic cc_zero;
		logic cc_one;
		logic idx_end;
		logic idx_last;
		logic len_zero;
		logic dec_len_ok;
		logic salt_bit;
		logic plain_ok;
		logic md5_busy;
		logic out_free;
	} tpc_stat_t;

	// MD5 round constants.
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// MD5 rotate amounts, indexed by {round group, round mod 4}.
	function automatic logic [4:0] md5_s(input logic [3:0] j);
		logic [4:0] s;
		case (j)
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### rtl/tpc_md5.sv
// Iterative MD5 unit: one round per cycle over secret followed by a short tail.
`default_nettype none
module tpc_md5
	import tpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        tail16,
	input  tail_t            tail,
	input  bytes32_t         secret,
	input  wire logic [5:0]  secret_length,
	output logic             busy,
	output block16_t         digest
);

	logic        busy_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	tail_t       tail_q;
	logic        tail16_q;
	block16_t    digest_q;

	logic [5:0]  n_len, m_len;
	logic [3:0]  g;
	logic [31:0] f, msg, tmp, rot, b_n;
	logic [63:0] dbl;

	// Padded message byte at position p of the single block.
	function automatic logic [7:0] msg_byte(input logic [5:0] p, input logic [5:0] n,
		input logic [5:0] m, input bytes32_t sec, input tail_t tl);
		logic [5:0] off;
		logic [7:0] r;
		off = p - n;
		r = 8'h00;
		if (p < n) begin
			r = sec[p[4:0]];
		end else if (p < m) begin
			r = tl[off[4:0]];
		end else if (p == m) begin
			r = 8'h80;
		end else if (p == 6'd56) begin
			r = {m[4:0], 3'b000};
		end else if (p == 6'd57) begin
			r = {7'b0, m[5]};
		end
		return r;
	endfunction

	// Message length: clamped secret plus the tail.
	always_comb begin
		n_len = (secret_length > MAX_SECRET_BYTES) ? MAX_SECRET_BYTES : secret_length;
		m_len = n_len + (tail16_q ? 6'd16 : 6'd18);
	end

	// One MD5 round.
	always_comb begin
		case (rnd_q[5:4])
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = rnd_q[3:0];
			end
			2'd1: begin
				f = (d_q & b_q) | (~d_q & c_q);
				g = 4'(rnd_q[3:0] * 4'd5 + 4'd1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(rnd_q[3:0] * 4'd3 + 4'd5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(rnd_q[3:0] * 4'd7);
			end
		endcase
		msg = {msg_byte({g, 2'd3}, n_len, m_len, secret, tail_q),
		       msg_byte({g, 2'd2}, n_len, m_len, secret, tail_q),
		       msg_byte({g, 2'd1}, n_len, m_len, secret, tail_q),
		       msg_byte({g, 2'd0}, n_len, m_len, secret, tail_q)};
		tmp = f + a_q + md5_k(rnd_q) + msg;
		dbl = {tmp, tmp} << md5_s({rnd_q[5:4], rnd_q[1:0]});
		rot = dbl[63:32];
		b_n = b_q + rot;
	end

	// Round counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= 6'd0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 6'd1;
			if (rnd_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Working variables, tail capture and final digest.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= MD5_A0;
			b_q      <= MD5_B0;
			c_q      <= MD5_C0;
			d_q      <= MD5_D0;
			tail_q   <= tail;
			tail16_q <= tail16;
		end else if (busy_q) begin
			a_q <= d_q;
			b_q <= b_n;
			c_q <= b_q;
			d_q <= c_q;
			if (rnd_q == 6'd63) begin
				digest_q <= {{<<8{32'(MD5_A0 + d_q)}}, {<<8{32'(MD5_B0 + b_n)}},
				             {<<8{32'(MD5_C0 + b_q)}}, {<<8{32'(MD5_D0 + c_q)}}};
			end
		end
	end

	assign busy   = busy_q;
	assign digest = digest_q;

endmodule
`default_nettype wire

### rtl/tpc_dp.sv
// Datapath: attribute stores, counters, chunk buffers, MD5 unit and result register.
`default_nettype none
module tpc_dp
	import tpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  tpc_cmd_t         ctl,
	output tpc_stat_t        stat,
	input  bytes32_t         secret,
	input  wire logic [5:0]  secret_length,
	input  wire logic [63:0] auth_hi,
	input  wire logic [63:0] auth_lo,
	input  wire logic [15:0] salt_in,
	input  wire logic [7:0]  attr_len,
	input  wire logic [7:0]  data_byte,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [1:0]       status
);

	logic [63:0] auth_hi_q, auth_lo_q;
	logic [15:0] salt_q;
	logic [7:0]  pass_q;
	block16_t    chunk_q, obuf_q, obuf_d;
	logic [4:0]  bpos_q, idx_q;
	logic [7:0]  bl_q, cc_q;
	logic        out_valid_q, out_last_q;
	logic [7:0]  out_byte_q, out_byte_d;
	logic [1:0]  status_q;

	logic        md5_busy;
	block16_t    digest;
	tail_t       md5_tail;
	logic [7:0]  plain0;

	tpc_md5 u_md5 (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (ctl.md5_seed | ctl.md5_chain),
		.tail16        (ctl.md5_chain),
		.tail          (md5_tail),
		.secret        (secret),
		.secret_length (secret_length),
		.busy          (md5_busy),
		.digest        (digest)
	);

	// Digest input: authenticator and salt, or the previous ciphertext chunk.
	always_comb begin
		if (ctl.md5_seed) begin
			md5_tail = {auth_hi_q, auth_lo_q, salt_q};
		end else if (ctl.enc) begin
			md5_tail = {obuf_q, 16'h0};
		end else begin
			md5_tail = {chunk_q, 16'h0};
		end
	end

	// Chunk XOR digest, with zero padding past the fill point when encrypting.
	always_comb begin
		for (int j = 0; j < 16; j++) begin
			if (ctl.enc && (5'(j) >= bpos_q)) begin
				obuf_d[j] = digest[j];
			end else begin
				obuf_d[j] = chunk_q[j] ^ digest[j];
			end
		end
		plain0 = chunk_q[0] ^ digest[0];
	end

	// Status toward the controller.
	always_comb begin
		stat.bpos_zero  = (bpos_q == 5'd0);
		stat.bpos_last  = (bpos_q == 5'd15);
		stat.bl_zero    = (bl_q == 8'd0);
		stat.bl_one     = (bl_q == 8'd1);
		stat.cc_zero    = (cc_q == 8'd0);
		stat.cc_one     = (cc_q == 8'd1);
		stat.idx_end    = (idx_q == 5'd16);
		stat.idx_last   = (idx_q == 5'd15);
		stat.len_zero   = (attr_len == 8'd0);
		stat.dec_len_ok = (attr_len >= 8'd18) && (attr_len[3:0] == 4'd2);
		stat.salt_bit   = salt_q[15];
		stat.plain_ok   = ({1'b0, plain0} >= {1'b0, bl_q}) &&
		                  ({1'b0, plain0} <= ({1'b0, bl_q} + 9'd15));
		stat.md5_busy   = md5_busy;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// Byte position, remaining length, clear count and emit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q <= 5'd0;
			bl_q   <= 8'd0;
			cc_q   <= 8'd0;
			idx_q  <= 5'd0;
		end else begin
			if (ctl.ld_len_byte) begin
				bpos_q <= 5'd1;
			end else if (ctl.clr_bpos || ctl.ld_obuf) begin
				bpos_q <= 5'd0;
			end else if (ctl.wr_chunk) begin
				bpos_q <= bpos_q + 5'd1;
			end else if (ctl.wr_salt) begin
				bpos_q <= (bpos_q == 5'd0) ? 5'd1 : 5'd0;
			end
			if (ctl.ld_bl_len) begin
				bl_q <= attr_len;
			end else if (ctl.dec_bl) begin
				bl_q <= bl_q - 8'd1;
			end
			if (ctl.ld_obuf && ctl.first_chunk) begin
				cc_q <= plain0;
			end else if (ctl.cc_dec) begin
				cc_q <= cc_q - 8'd1;
			end
			if (ctl.ld_obuf) begin
				idx_q <= ctl.first_chunk ? 5'd1 : 5'd0;
			end else if (ctl.step) begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	// Attribute payload stores.
	always_ff @(posedge clk) begin
		if (ctl.ld_auth) begin
			auth_hi_q <= auth_hi;
			auth_lo_q <= auth_lo;
		end
		if (ctl.ld_salt_enc) begin
			salt_q <= salt_in | SALT_MARK;
		end else if (ctl.wr_salt) begin
			if (bpos_q == 5'd0) begin
				salt_q <= {data_byte, 8'h00};
			end else begin
				salt_q <= {salt_q[15:8], data_byte};
			end
		end
		if (ctl.ld_len_byte) begin
			chunk_q[0] <= attr_len;
		end else if (ctl.wr_chunk) begin
			chunk_q[bpos_q[3:0]] <= data_byte;
		end
		if (ctl.ld_pass) begin
			pass_q <= data_byte;
		end
		if (ctl.ld_obuf) begin
			obuf_q <= obuf_d;
		end
	end

	// Result byte selection.
	always_comb begin
		case (ctl.src)
			SRC_SALT_HI: out_byte_d = salt_q[15:8];
			SRC_SALT_LO: out_byte_d = salt_q[7:0];
			SRC_OBUF:    out_byte_d = obuf_q[idx_q[3:0]];
			SRC_PASS:    out_byte_d = pass_q;
			default:     out_byte_d = 8'h00;
		endcase
	end

	// Result register; a transfer frees it for the next result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_byte_q <= out_byte_d;
			out_last_q <= ctl.last;
			status_q   <= ctl.code;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign status    = status_q;

	// A result is only loaded when the result register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transfer");

	// The chunk is combined with the digest only once the digest is finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_obuf |-> !md5_busy)
		else $error("chunk combined with an unfinished digest");

	// Fill point and emit index stay within one chunk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(bpos_q <= 5'd16) && (idx_q <= 5'd16))
		else $error("chunk position out of range");

	// An emitted buffer byte always comes from inside the chunk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.src == SRC_OBUF) |-> (idx_q < 5'd16))
		else $error("emit past end of chunk");

endmodule
`default_nettype wire

### rtl/tpc_ctrl.sv
// Controller: attribute phase and sequencing of accepts, digests and result emission.
`default_nettype none
module tpc_ctrl
	import tpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       cmd,
	input  wire logic [1:0] cipher_mode,
	input  tpc_stat_t       stat,
	output tpc_cmd_t        ctl
);

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;
	logic [1:0]  err_q, err_d;
	logic        dec_side, emit_stop;

	assign dec_side  = (phase_q != PH_ENC);
	assign emit_stop = stat.idx_end || (dec_side && stat.cc_zero);
	assign in_ready  = (state_q == S_IN);

	// Next state and phase.
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		err_d   = err_q;
		case (state_q)
			S_IN: begin
				if (in_valid) begin
					if (cmd == CMD_START) begin
						phase_d = PH_NONE;
						case (cipher_mode)
							MODE_CLEAR: begin
								if (!stat.len_zero) phase_d = PH_CLEAR;
							end
							MODE_ENC: begin
								phase_d = PH_ENC;
								state_d = S_SEED;
							end
							MODE_DEC: begin
								if (stat.dec_len_ok) begin
									phase_d = PH_DSALT;
								end else begin
									err_d   = ST_BAD_CLEN;
									state_d = S_ERR;
								end
							end
							default: ;
						endcase
					end else begin
						case (phase_q)
							PH_CLEAR: begin
								state_d = S_PASS;
								if (stat.bl_one) phase_d = PH_NONE;
							end
							PH_ENC: begin
								if (stat.bpos_last || stat.bl_one) state_d = S_WAIT;
							end
							PH_DSALT: begin
								if (!stat.bpos_zero) begin
									if (!stat.salt_bit) begin
										err_d   = ST_SALT;
										state_d = S_ERR;
										phase_d = PH_NONE;
									end else begin
										phase_d = PH_DFIRST;
										state_d = S_SEED;
									end
								end
							end
							PH_DFIRST, PH_DREST: begin
								if (stat.bpos_last) state_d = S_WAIT;
							end
							default: ;
						endcase
					end
				end
			end
			S_SEED: begin
				state_d = (phase_q == PH_ENC) ? S_SALT_HI : S_IN;
			end
			S_SALT_HI: begin
				if (stat.out_free) state_d = S_SALT_LO;
			end
			S_SALT_LO: begin
				if (stat.out_free) state_d = stat.bl_zero ? S_WAIT : S_IN;
			end
			S_WAIT: begin
				if (!stat.md5_busy) state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = S_EMIT;
				if (phase_q == PH_DFIRST) begin
					if (stat.plain_ok) begin
						phase_d = PH_DREST;
					end else begin
						err_d   = ST_BAD_PLEN;
						state_d = S_ERR;
						phase_d = PH_NONE;
					end
				end
			end
			S_EMIT: begin
				if (emit_stop) state_d = S_NEXT;
			end
			S_NEXT: begin
				if (stat.bl_zero) phase_d = PH_NONE;
				state_d = S_IN;
			end
			S_PASS, S_ERR: begin
				if (stat.out_free) state_d = S_IN;
			end
			default: state_d = S_IN;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		ctl = '0;
		ctl.src  = SRC_ERR;
		ctl.code = ST_OK;
		ctl.enc  = (phase_q == PH_ENC);
		case (state_q)
			S_IN: begin
				if (in_valid) begin
					if (cmd == CMD_START) begin
						ctl.ld_auth  = 1'b1;
						ctl.clr_bpos = 1'b1;
						case (cipher_mode)
							MODE_CLEAR: ctl.ld_bl_len = 1'b1;
							MODE_ENC: begin
								ctl.ld_bl_len   = 1'b1;
								ctl.ld_salt_enc = 1'b1;
								ctl.ld_len_byte = 1'b1;
							end
							MODE_DEC: ctl.ld_bl_len = stat.dec_len_ok;
							default: ;
						endcase
					end else begin
						case (phase_q)
							PH_CLEAR: begin
								ctl.dec_bl  = 1'b1;
								ctl.ld_pass = 1'b1;
							end
							PH_ENC, PH_DFIRST, PH_DREST: begin
								ctl.dec_bl   = 1'b1;
								ctl.wr_chunk = 1'b1;
							end
							PH_DSALT: begin
								ctl.dec_bl  = 1'b1;
								ctl.wr_salt = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			S_SEED: ctl.md5_seed = 1'b1;
			S_SALT_HI: begin
				ctl.emit = stat.out_free;
				ctl.src  = SRC_SALT_HI;
			end
			S_SALT_LO: begin
				ctl.emit = stat.out_free;
				ctl.src  = SRC_SALT_LO;
			end
			S_LOAD: begin
				ctl.ld_obuf     = 1'b1;
				ctl.first_chunk = (phase_q == PH_DFIRST);
			end
			S_EMIT: begin
				ctl.src = SRC_OBUF;
				if (!emit_stop && stat.out_free) begin
					ctl.emit   = 1'b1;
					ctl.step   = 1'b1;
					ctl.cc_dec = dec_side;
					ctl.last   = dec_side ? stat.cc_one : (stat.idx_last && stat.bl_zero);
				end
			end
			S_NEXT: ctl.md5_chain = !stat.bl_zero;
			S_PASS: begin
				ctl.emit = stat.out_free;
				ctl.src  = SRC_PASS;
				ctl.last = stat.bl_zero;
			end
			S_ERR: begin
				ctl.emit = stat.out_free;
				ctl.src  = SRC_ERR;
				ctl.last = 1'b1;
				ctl.code = err_q;
			end
			default: ;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			phase_q <= PH_NONE;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			err_q   <= err_d;
		end
	end

	// An error result always carries a failure code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR) |-> (err_q != ST_OK))
		else $error("error result without a failure code");

	// The chunk is emitted only after being combined with its digest.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && $past(state_q) != S_EMIT) |-> ($past(state_q) == S_LOAD))
		else $error("chunk emission entered without loading");

	// The salt is emitted only in encrypt mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SALT_HI || state_q == S_SALT_LO) |-> (phase_q == PH_ENC))
		else $error("salt emitted outside encryption");

endmodule
`default_nettype wire

### rtl/tunnel_password_cipher.sv
// Top level: configuration registers, controller and datapath of the tunnel password cipher.
// Timing: a data byte is taken while in_ready is high; a chunk's digest runs one MD5 round per
// cycle, then the chunk's result transfers follow, one per cycle while out_ready keeps up.
// The shared MD5 round unit bounds throughput; a chunk's digest runs while its bytes are taken.
// Encrypt start items emit two salt bytes; the salt digest runs while data is taken.
// Reset: arst_n clears the controller, counters and configuration asynchronously.
`default_nettype none
module tunnel_password_cipher
	import tpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire logic [63:0]       auth_hi,
	input  wire logic [63:0]       auth_lo,
	input  wire logic [15:0]       salt_in,
	input  wire logic [7:0]        attr_len,
	input  wire logic [7:0]        data_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_last,
	output logic [1:0]             status
);

	logic [63:0] secret_word0_q, secret_word1_q, secret_word2_q, secret_word3_q;
	logic [5:0]  secret_length_q;
	logic [1:0]  cipher_mode_q;
	logic        wr_en;
	bytes32_t    secret;
	tpc_cmd_t    ctl;
	tpc_stat_t   stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign secret = {secret_word0_q, secret_word1_q, secret_word2_q, secret_word3_q};

	// Register writes on the access phase of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_word0_q  <= '0;
			secret_word1_q  <= '0;
			secret_word2_q  <= '0;
			secret_word3_q  <= '0;
			secret_length_q <= '0;
			cipher_mode_q   <= MODE_CLEAR;
		end else if (wr_en) begin
			case (paddr[5:3])
				REG_SECRET0: secret_word0_q  <= pwdata;
				REG_SECRET1: secret_word1_q  <= pwdata;
				REG_SECRET2: secret_word2_q  <= pwdata;
				REG_SECRET3: secret_word3_q  <= pwdata;
				REG_SECLEN:  secret_length_q <= pwdata[5:0];
				REG_MODE:    cipher_mode_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[5:3])
			REG_SECRET0: prdata = secret_word0_q;
			REG_SECRET1: prdata = secret_word1_q;
			REG_SECRET2: prdata = secret_word2_q;
			REG_SECRET3: prdata = secret_word3_q;
			REG_SECLEN:  prdata = {58'b0, secret_length_q};
			REG_MODE:    prdata = {62'b0, cipher_mode_q};
			default:     prdata = '0;
		endcase
	end

	tpc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.cipher_mode (cipher_mode_q),
		.stat        (stat),
		.ctl         (ctl)
	);

	tpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.secret        (secret),
		.secret_length (secret_length_q),
		.auth_hi       (auth_hi),
		.auth_lo       (auth_lo),
		.salt_in       (salt_in),
		.attr_len      (attr_len),
		.data_byte     (data_byte),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.status        (status)
	);

endmodule
`default_nettype wire
